// File: rtl/c3z_pkg.sv
// ----------------------------------------------------------------------------
// c3z_pkg
// Shared widths, register indexes, reset values and types of the 3x3
// convolution block.
// ----------------------------------------------------------------------------
package c3z_pkg;

    localparam int MAX_SIZE = 1024;
    localparam int ADDR_W   = $clog2(MAX_SIZE);

    localparam int PIX_W    = 8;
    localparam int POS_W    = 10;
    localparam int FRAME_W  = 11;
    localparam int COEF_W   = 8;
    localparam int ROW_W    = 3 * COEF_W;
    localparam int CFG_W    = 24;
    localparam int IDX_W    = 2;
    localparam int PROD_W   = PIX_W + COEF_W + 1;
    localparam int RSUM_W   = PROD_W + 2;
    localparam int VAL_W    = 20;
    localparam int IN_W     = 8;
    localparam int OUT_W    = 40;

    localparam logic [IDX_W-1:0] REG_FRAME_SIZE = 2'd0;
    localparam logic [IDX_W-1:0] REG_COEF_TOP   = 2'd1;
    localparam logic [IDX_W-1:0] REG_COEF_MID   = 2'd2;
    localparam logic [IDX_W-1:0] REG_COEF_BOT   = 2'd3;

    localparam logic [FRAME_W-1:0] FRAME_RST    = 11'd8;
    localparam logic [ROW_W-1:0]   COEF_TOP_RST = 24'h0100FF;
    localparam logic [ROW_W-1:0]   COEF_MID_RST = 24'h0200FE;
    localparam logic [ROW_W-1:0]   COEF_BOT_RST = 24'h0100FF;

    // window[row][col], row 0 is the oldest line, col 0 the oldest column
    typedef logic [2:0][2:0][PIX_W-1:0] t_win;
    typedef logic [2:0][ROW_W-1:0]      t_coef;

    typedef struct packed {
        logic             interior;
        logic             last;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_ctl;

endpackage

// File: rtl/c3z_mac.sv
// ----------------------------------------------------------------------------
// c3z_mac
// Nine pixel by coefficient products, registered, then three row sums,
// registered; the total of the row sums leaves combinationally.
// ----------------------------------------------------------------------------
module c3z_mac (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  c3z_pkg::t_win                          i_win,
    input  c3z_pkg::t_coef                         i_coef,
    output logic signed [c3z_pkg::VAL_W-1:0]       o_sum
);

    logic signed [c3z_pkg::PROD_W-1:0] r_prod [3][3];
    logic signed [c3z_pkg::PROD_W-1:0] n_prod [3][3];
    logic signed [c3z_pkg::RSUM_W-1:0] r_rsum [3];
    logic signed [c3z_pkg::RSUM_W-1:0] n_rsum [3];

    always_comb begin
        logic signed [c3z_pkg::PIX_W:0]    pix;
        logic signed [c3z_pkg::COEF_W-1:0] cf;
        for (int k = 0; k < 3; k++) begin
            for (int l = 0; l < 3; l++) begin
                pix = $signed({1'b0, i_win[k][l]});
                cf  = $signed(i_coef[k][l*c3z_pkg::COEF_W +: c3z_pkg::COEF_W]);
                n_prod[k][l] = c3z_pkg::PROD_W'(pix) * c3z_pkg::PROD_W'(cf);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_rsum[k] = c3z_pkg::RSUM_W'(r_prod[k][0]) + c3z_pkg::RSUM_W'(r_prod[k][1])
                      + c3z_pkg::RSUM_W'(r_prod[k][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_rsum <= n_rsum;
        end
    end

    assign o_sum = c3z_pkg::VAL_W'(r_rsum[0]) + c3z_pkg::VAL_W'(r_rsum[1])
                 + c3z_pkg::VAL_W'(r_rsum[2]);

endmodule

// File: rtl/convolution_3x3_zero_border_top.sv
// ----------------------------------------------------------------------------
// convolution_3x3_zero_border_top
// 3x3 convolution over a square raster frame with a zero border.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless stalled; a pixel at row r, column c with r and c
// both nonzero gives the result for position (r-1, c-1), and results can leave one
// per clock. The result's tvalid is registered through r_v1 to r_v4 and r_out_vld;
// the whole pipeline advances together and stalls only while a result waits on
// the output. The two line stores are single memories of MAX_SIZE x 8 bits,
// read once and written once per pixel; the older store is written in the cycle
// after the read of the newer one, with a bypass for a read of that same
// entry. Write the registers only while no pixel is in the pipeline.
module convolution_3x3_zero_border_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [c3z_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [c3z_pkg::CFG_W-1:0]     i_cfg_wr_data,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [c3z_pkg::IN_W-1:0]      i_s_axis_tdata,   // pixel[7:0]
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [c3z_pkg::OUT_W-1:0]     o_m_axis_tdata,   // out_row[9:0], out_col[19:10],
                                                            // value[39:20]
    output logic                          o_m_axis_tlast
);

    logic [c3z_pkg::FRAME_W-1:0] r_frame_size;
    c3z_pkg::t_coef              r_coef;

    logic [c3z_pkg::POS_W-1:0]   r_row, r_col;
    logic [c3z_pkg::POS_W-1:0]   w_last_idx;
    logic [c3z_pkg::POS_W-1:0]   w_rr, w_cc;
    logic [c3z_pkg::ADDR_W-1:0]  w_addr;
    logic                        w_en, w_accept, w_at_end, w_col_end;

    logic [c3z_pkg::PIX_W-1:0]   r_line_a [c3z_pkg::MAX_SIZE];
    logic [c3z_pkg::PIX_W-1:0]   r_line_b [c3z_pkg::MAX_SIZE];
    logic [c3z_pkg::PIX_W-1:0]   r_rd_a, r_rd_b, r_fwd_px, r_px1;
    logic                        r_fwd, r_wb_vld;
    logic [c3z_pkg::ADDR_W-1:0]  r_wb_addr;

    logic                        r_v1, r_v2, r_v3, r_v4, r_out_vld;
    logic                        r_emit1;
    c3z_pkg::t_ctl               r_ctl1, r_ctl2, r_ctl3, r_ctl4, n_ctl1;
    c3z_pkg::t_win               r_win;
    logic [c3z_pkg::PIX_W-1:0]   w_b_px;
    logic signed [c3z_pkg::VAL_W-1:0] w_sum;
    logic [c3z_pkg::OUT_W-1:0]   r_tdata;
    logic                        r_tlast;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_size <= c3z_pkg::FRAME_RST;
            r_coef[0]    <= c3z_pkg::COEF_TOP_RST;
            r_coef[1]    <= c3z_pkg::COEF_MID_RST;
            r_coef[2]    <= c3z_pkg::COEF_BOT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                c3z_pkg::REG_FRAME_SIZE: r_frame_size <= i_cfg_wr_data[c3z_pkg::FRAME_W-1:0];
                c3z_pkg::REG_COEF_TOP:   r_coef[0]    <= i_cfg_wr_data;
                c3z_pkg::REG_COEF_MID:   r_coef[1]    <= i_cfg_wr_data;
                c3z_pkg::REG_COEF_BOT:   r_coef[2]    <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    // last row/column index of the clamped frame side
    always_comb begin
        priority if (r_frame_size == '0) begin
            w_last_idx = '0;
        end else if (r_frame_size > c3z_pkg::FRAME_W'(c3z_pkg::MAX_SIZE)) begin
            w_last_idx = c3z_pkg::POS_W'(c3z_pkg::MAX_SIZE - 1);
        end else begin
            w_last_idx = c3z_pkg::POS_W'(r_frame_size - 1'b1);
        end
    end

    assign w_en            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en && i_rst_n;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_col_end       = r_col >= w_last_idx;
    assign w_at_end        = (r_row >= w_last_idx) && w_col_end;
    assign w_rr            = r_row - 1'b1;
    assign w_cc            = r_col - 1'b1;
    assign w_addr          = c3z_pkg::ADDR_W'(r_col);

    always_comb begin
        n_ctl1.interior = (w_rr != '0) && (w_cc != '0)
                       && (w_rr < w_last_idx) && (w_cc < w_last_idx);
        n_ctl1.last     = w_at_end;
        n_ctl1.row      = w_rr;
        n_ctl1.col      = w_cc;
    end

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (w_accept) begin
            priority if (w_at_end) begin
                r_row <= '0;
                r_col <= '0;
            end else if (w_col_end) begin
                r_row <= r_row + 1'b1;
                r_col <= '0;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // newer line store: read old entry, write new pixel
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_a           <= r_line_a[w_addr];
            r_line_a[w_addr] <= i_s_axis_tdata[c3z_pkg::PIX_W-1:0];
        end
    end

    // older line store: takes the newer store's old entry, registered in r_rd_a
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_b <= r_line_b[w_addr];
        end
        if (r_wb_vld) begin
            r_line_b[r_wb_addr] <= r_rd_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_vld <= 1'b0;
        end else begin
            r_wb_vld <= w_accept;
        end
        if (w_accept) begin
            r_wb_addr <= w_addr;
            r_fwd     <= r_wb_vld && (r_wb_addr == w_addr);
            r_fwd_px  <= r_rd_a;
            r_px1     <= i_s_axis_tdata[c3z_pkg::PIX_W-1:0];
            r_emit1   <= (r_row != '0) && (r_col != '0);
            r_ctl1    <= n_ctl1;
        end
    end

    assign w_b_px = r_fwd ? r_fwd_px : r_rd_b;

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_v1      <= w_accept;
            r_v2      <= r_v1 && r_emit1;
            r_v3      <= r_v2;
            r_v4      <= r_v3;
            r_out_vld <= r_v4;
        end
    end

    // window shift and control pipeline
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_v1) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k][0] <= r_win[k][1];
                    r_win[k][1] <= r_win[k][2];
                end
                r_win[0][2] <= w_b_px;
                r_win[1][2] <= r_rd_a;
                r_win[2][2] <= r_px1;
            end
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
            r_ctl4 <= r_ctl3;
        end
    end

    c3z_mac u_mac (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_win  (r_win),
        .i_coef (r_coef),
        .o_sum  (w_sum)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tdata <= {(r_ctl4.interior ? w_sum : c3z_pkg::VAL_W'(0)),
                        r_ctl4.col, r_ctl4.row};
            r_tlast <= r_ctl4.last;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_tdata;
    assign o_m_axis_tlast  = r_tlast;

`ifndef SYNTHESIS
    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[9:0] == '0 || o_m_axis_tdata[19:10] == '0)
        |-> o_m_axis_tdata[39:20] == '0)
        else $error("border result not zero");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && !r_v1 && !r_wb_vld)
        else $error("pipeline not cleared by reset");

    a_writeback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_wb_vld && r_wb_addr == $past(w_addr))
        else $error("line store write-back missing");
`endif

endmodule

// File: tb/sv/tb_convolution_3x3_zero_border_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_convolution_3x3_zero_border_top
// Self-checking bench for the 3x3 zero-border convolution block.
// ----------------------------------------------------------------------------
// Pixels stream in through the slave port from a queue. Each transfer updates
// a local line-store / window model that predicts the result for position
// (r-1, c-1). The monitor compares every output transfer against the oldest
// prediction. Phases change the frame size and the kernel while the block is
// drained, and cycle through source idling, sink stalls, a long sink hold-off
// and a mid-frame source pause. The last phase runs a saturated frame size.
// ----------------------------------------------------------------------------
module tb_convolution_3x3_zero_border_top;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RAND_PIXELS    = 380;

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} t_idle_mode;

    typedef struct {
        logic [c3z_pkg::POS_W-1:0] row;
        logic [c3z_pkg::POS_W-1:0] col;
        logic [c3z_pkg::VAL_W-1:0] value;
        logic                      last;
    } t_conv_res;

    logic                        i_clk           = 1'b0;
    logic                        i_rst_n         = 1'b0;
    logic                        i_cfg_wr_en     = 1'b0;
    logic [c3z_pkg::IDX_W-1:0]   i_cfg_idx       = '0;
    logic [c3z_pkg::CFG_W-1:0]   i_cfg_wr_data   = '0;
    logic                        i_s_axis_tvalid = 1'b0;
    logic                        o_s_axis_tready;
    logic [c3z_pkg::IN_W-1:0]    i_s_axis_tdata  = '0;
    logic                        o_m_axis_tvalid;
    logic                        i_m_axis_tready = 1'b0;
    logic [c3z_pkg::OUT_W-1:0]   o_m_axis_tdata;
    logic                        o_m_axis_tlast;

    convolution_3x3_zero_border_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // model state and register copies
    logic [c3z_pkg::PIX_W-1:0]   prev_line [c3z_pkg::MAX_SIZE];
    logic [c3z_pkg::PIX_W-1:0]   older_line[c3z_pkg::MAX_SIZE];
    logic [c3z_pkg::PIX_W-1:0]   win3[3][3];
    int unsigned                 row_cnt;
    int unsigned                 col_cnt;
    logic [c3z_pkg::FRAME_W-1:0] frame_sz  = c3z_pkg::FRAME_RST;
    c3z_pkg::t_coef              kern_rows = {c3z_pkg::COEF_BOT_RST, c3z_pkg::COEF_MID_RST,
                                              c3z_pkg::COEF_TOP_RST};

    logic [c3z_pkg::PIX_W-1:0] pixel_q[$];
    t_conv_res                 conv_q[$];

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_trig     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int err_cnt       = 0;
    int px_accepted   = 0;
    int res_checked   = 0;
    int phase_cnt     = 0;
    int idle_cyc      = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void conv_predict(input logic [c3z_pkg::PIX_W-1:0] px);
        int unsigned n;
        int unsigned r;
        int unsigned c;
        int unsigned idx;
        int          sum;
        bit          at_end;
        t_conv_res   res;
        n = frame_sz;
        if (n == 0) n = 1;
        if (n > c3z_pkg::MAX_SIZE) n = c3z_pkg::MAX_SIZE;
        r = row_cnt;
        c = col_cnt;
        idx = c % c3z_pkg::MAX_SIZE;
        at_end = (r >= n - 1) && (c >= n - 1);
        for (int k = 0; k < 3; k++) begin
            win3[k][0] = win3[k][1];
            win3[k][1] = win3[k][2];
        end
        win3[0][2] = older_line[idx];
        win3[1][2] = prev_line[idx];
        win3[2][2] = px;
        older_line[idx] = prev_line[idx];
        prev_line[idx] = px;
        if (r >= 1 && c >= 1) begin
            sum = 0;
            if (r - 1 != 0 && c - 1 != 0 && r - 1 < n - 1 && c - 1 < n - 1) begin
                for (int k = 0; k < 3; k++)
                    for (int l = 0; l < 3; l++)
                        sum += int'(win3[k][l]) * int'($signed(kern_rows[k][8*l +: 8]));
            end
            res.row   = c3z_pkg::POS_W'(r - 1);
            res.col   = c3z_pkg::POS_W'(c - 1);
            res.value = sum[c3z_pkg::VAL_W-1:0];
            res.last  = at_end;
            conv_q.push_back(res);
        end
        if (at_end) begin
            row_cnt = 0;
            col_cnt = 0;
        end else if (c >= n - 1) begin
            col_cnt = 0;
            row_cnt = r + 1;
        end else begin
            col_cnt = c + 1;
        end
    endfunction

    // source: offer queued pixels, hold while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                conv_predict(i_s_axis_tdata);
                px_accepted++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pixel_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= pixel_q.pop_front();
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink: check each transfer, stall at random or for a hold-off
    always @(posedge i_clk) begin : sink
        t_conv_res exp_res;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                res_checked++;
                if (conv_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("ERROR: result with nothing expected: row %0d col %0d",
                                 o_m_axis_tdata[9:0], o_m_axis_tdata[19:10]);
                end else begin
                    exp_res = conv_q.pop_front();
                    if (o_m_axis_tdata[9:0] !== exp_res.row ||
                        o_m_axis_tdata[19:10] !== exp_res.col ||
                        o_m_axis_tdata[39:20] !== exp_res.value ||
                        o_m_axis_tlast !== exp_res.last) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display({"ERROR: exp row %0d col %0d value %0d last %0b, ",
                                      "got row %0d col %0d value %0d last %0b"},
                                     exp_res.row, exp_res.col, $signed(exp_res.value),
                                     exp_res.last, o_m_axis_tdata[9:0],
                                     o_m_axis_tdata[19:10],
                                     $signed(o_m_axis_tdata[39:20]), o_m_axis_tlast);
                    end
                end
            end
            if (hold_seen != hold_trig) begin
                hold_seen = hold_trig;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cyc <= 0;
        end else if (idle_cyc >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            idle_cyc <= idle_cyc + 1;
        end
    end

    task automatic write_reg(input logic [c3z_pkg::IDX_W-1:0] idx,
                             input logic [c3z_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_idx     <= idx;
        i_cfg_wr_data <= data;
        case (idx)
            c3z_pkg::REG_FRAME_SIZE: frame_sz = data[c3z_pkg::FRAME_W-1:0];
            c3z_pkg::REG_COEF_TOP:   kern_rows[0] = data;
            c3z_pkg::REG_COEF_MID:   kern_rows[1] = data;
            c3z_pkg::REG_COEF_BOT:   kern_rows[2] = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pixel_q.size() != 0 || i_s_axis_tvalid || conv_q.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_idling(input t_idle_mode mode);
        src_idle_pct  = (mode == IDLE_SRC) ? 81 : (mode == IDLE_BOTH) ? 17 : 0;
        snk_stall_pct = (mode == IDLE_SNK) ? 81 : (mode == IDLE_BOTH) ? 17 : 0;
    endtask

    function automatic logic [c3z_pkg::PIX_W-1:0] rand_pixel();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return c3z_pkg::PIX_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [c3z_pkg::ROW_W-1:0] rand_kernel_row();
        case ($urandom_range(5))
            0:       return 24'h808080;
            1:       return 24'h7F7F7F;
            2:       return 24'h000000;
            3:       return 24'hFFFFFF;
            default: return c3z_pkg::ROW_W'($urandom());
        endcase
    endfunction

    function automatic int unsigned pick_frame_size();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8) return $urandom_range(1);
        if (roll < 18) return 3;
        if (roll < 85) return $urandom_range(10, 2);
        return $urandom_range(16, 11);
    endfunction

    task automatic push_pixels(input int cnt);
        for (int i = 0; i < cnt; i++)
            pixel_q.push_back(rand_pixel());
    endtask

    task automatic push_const_frame(input int side, input logic [c3z_pkg::PIX_W-1:0] px);
        for (int i = 0; i < side * side; i++)
            pixel_q.push_back(px);
    endtask

    initial begin : stimulus
        int unsigned n;
        int unsigned side;
        int          frames;
        int          rand_px;
        for (int i = 0; i < c3z_pkg::MAX_SIZE; i++) begin
            prev_line[i]  = '0;
            older_line[i] = '0;
        end
        for (int k = 0; k < 3; k++)
            for (int l = 0; l < 3; l++)
                win3[k][l] = '0;
        row_cnt = 0;
        col_cnt = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(IDLE_NONE);

        // directed: kernel extremes on a minimal frame, tiny and degenerate sizes
        write_reg(c3z_pkg::REG_FRAME_SIZE, 24'd3);
        write_reg(c3z_pkg::REG_COEF_TOP, 24'h808080);
        write_reg(c3z_pkg::REG_COEF_MID, 24'h808080);
        write_reg(c3z_pkg::REG_COEF_BOT, 24'h808080);
        push_const_frame(3, 8'hFF);
        wait_drained();
        write_reg(c3z_pkg::REG_COEF_TOP, 24'h7F7F7F);
        write_reg(c3z_pkg::REG_COEF_MID, 24'h7F7F7F);
        write_reg(c3z_pkg::REG_COEF_BOT, 24'h7F7F7F);
        push_const_frame(3, 8'hFF);
        wait_drained();
        write_reg(c3z_pkg::REG_FRAME_SIZE, 24'd1);
        pixel_q.push_back(8'h00);
        wait_drained();
        write_reg(c3z_pkg::REG_FRAME_SIZE, 24'd0);
        pixel_q.push_back(8'hFF);
        wait_drained();
        write_reg(c3z_pkg::REG_FRAME_SIZE, 24'd2);
        pixel_q.push_back(8'h00);
        pixel_q.push_back(8'hFF);
        pixel_q.push_back(8'h00);
        pixel_q.push_back(8'hFF);
        wait_drained();

        // reset-default kernel on the default frame size
        write_reg(c3z_pkg::REG_FRAME_SIZE, c3z_pkg::CFG_W'(c3z_pkg::FRAME_RST));
        write_reg(c3z_pkg::REG_COEF_TOP, c3z_pkg::COEF_TOP_RST);
        write_reg(c3z_pkg::REG_COEF_MID, c3z_pkg::COEF_MID_RST);
        write_reg(c3z_pkg::REG_COEF_BOT, c3z_pkg::COEF_BOT_RST);
        push_pixels(64);
        wait_drained();

        // long sink hold-off while the source keeps offering, then a mid-frame pause
        write_reg(c3z_pkg::REG_FRAME_SIZE, 24'd16);
        push_pixels(128);
        @(posedge i_clk);
        hold_trig <= hold_trig + 1;
        wait_drained();
        push_pixels(128);
        wait_drained();

        rand_px = 0;
        while (rand_px < RAND_PIXELS) begin
            if ($urandom_range(3) != 0)
                write_reg(c3z_pkg::REG_FRAME_SIZE, c3z_pkg::CFG_W'(pick_frame_size()));
            if ($urandom_range(1)) write_reg(c3z_pkg::REG_COEF_TOP, rand_kernel_row());
            if ($urandom_range(1)) write_reg(c3z_pkg::REG_COEF_MID, rand_kernel_row());
            if ($urandom_range(1)) write_reg(c3z_pkg::REG_COEF_BOT, rand_kernel_row());
            side = (frame_sz == 0) ? 1 : frame_sz;
            frames = 80 / (side * side);
            if (frames < 1) frames = 1;
            if (frames > 20) frames = 20;
            set_idling(t_idle_mode'(phase_cnt % 4));
            push_pixels(frames * side * side);
            rand_px += frames * side * side;
            phase_cnt++;
            wait_drained();
        end

        // frame size beyond the store depth saturates; run past the first row wrap
        set_idling(IDLE_BOTH);
        write_reg(c3z_pkg::REG_FRAME_SIZE, 24'h0007FF);
        write_reg(c3z_pkg::REG_COEF_TOP, rand_kernel_row());
        write_reg(c3z_pkg::REG_COEF_MID, rand_kernel_row());
        write_reg(c3z_pkg::REG_COEF_BOT, rand_kernel_row());
        n = c3z_pkg::MAX_SIZE + 40;
        push_pixels(n);
        wait_drained();

        err_cnt += conv_q.size();
        $display("Run covered %0d pixel transfers and %0d checked results in %0d random phases,",
                 px_accepted, res_checked, phase_cnt);
        $display("frame sizes 0 to 16 plus a saturated size, kernel extremes, idling and hold-off.");
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/c3z_pkg.sv
rtl/c3z_mac.sv
rtl/convolution_3x3_zero_border_top.sv
tb/sv/tb_convolution_3x3_zero_border_top.sv
